>>> hdl/range_address_translation_table_core_defines.svh
// Assertion macros shared by the range translation table checker.
// No dependencies; included by the checker file only.
`ifndef RANGE_ADDRESS_TRANSLATION_TABLE_CORE_DEFINES_SVH
`define RANGE_ADDRESS_TRANSLATION_TABLE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define RATT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RATT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ratt_pkg.sv
// Shared types and constants of the range address translation table.
// No dependencies.
`default_nettype none

package ratt_pkg;

  localparam int AddrW             = 64;
  localparam int StatusW           = 2;
  localparam int MaxEntriesDefault = 64;

  typedef enum logic {
    CmdInsert    = 1'b0,
    CmdTranslate = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StDup   = 2'd1,
    StFull  = 2'd2,
    StNoMap = 2'd3
  } status_e;

  // Request token moving down the cell chain. On a translate hit, len holds
  // the offset into the range and tgt the hit entry's physical base.
  typedef struct packed {
    logic             vld;
    cmd_e             cmd;
    logic             done;
    status_e          status;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] tgt;
  } tok_t;

endpackage

`default_nettype wire

>>> hdl/ratt_cell.sv
// One table entry plus the token register that links it to the next cell.
// Depends on ratt_pkg.
`default_nettype none

module ratt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire ratt_pkg::tok_t tok_i,
  output ratt_pkg::tok_t     tok_o
);
  import ratt_pkg::*;

  logic             occ_q;
  logic [AddrW-1:0] base_q, len_q, tgt_q;
  tok_t             tok_d, tok_q;
  logic             wr;
  logic [AddrW:0]   diff;

  assign diff = {1'b0, tok_i.addr} - {1'b0, base_q};

  always_comb begin
    tok_d = tok_i;
    wr    = 1'b0;
    if (tok_i.vld && !tok_i.done) begin
      if (tok_i.cmd == CmdInsert) begin
        if (occ_q && (base_q == tok_i.addr)) begin
          tok_d.done   = 1'b1;
          tok_d.status = StDup;
        end else if (!occ_q) begin
          // first free cell: every occupied cell ahead was checked
          wr           = 1'b1;
          tok_d.done   = 1'b1;
          tok_d.status = StOk;
        end
      end else begin
        if (occ_q && !diff[AddrW] && (diff[AddrW-1:0] < len_q)) begin
          tok_d.done   = 1'b1;
          tok_d.status = StOk;
          tok_d.len    = diff[AddrW-1:0];
          tok_d.tgt    = tgt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (wr) occ_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr) begin
      base_q <= tok_i.addr;
      len_q  <= tok_i.len;
      tgt_q  <= tok_i.tgt;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> hdl/range_address_translation_table_core.sv
// A request passes through MaxEntries cell registers and one output register.
// One request at a time: the token walks the chain one cell per cycle unless
// the exit is blocked, and the next request enters once it has left.
// Reset (async, active low) empties every cell and drops any request in flight.
// Depends on ratt_pkg and ratt_cell.
`default_nettype none

module range_address_translation_table_core #(
  parameter int MaxEntries = ratt_pkg::MaxEntriesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic [ratt_pkg::AddrW-1:0]   logical_addr_i,
  input  wire logic [ratt_pkg::AddrW-1:0]   range_length_i,
  input  wire logic [ratt_pkg::AddrW-1:0]   physical_base_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ratt_pkg::StatusW-1:0]      status_o,
  output logic [ratt_pkg::AddrW-1:0]        physical_addr_o
);
  import ratt_pkg::*;

  // tok[i] feeds cell i; tok[MaxEntries] leaves the last cell.
  tok_t tok [MaxEntries+1];

  tok_t             tok_in;     // incoming request token
  logic             busy_q;     // a request is inside the chain
  logic             in_acc;
  logic             adv;        // chain moves; held only when the exit is blocked
  logic             out_load;
  logic             out_vld_q;
  status_e          status_q, status_d;
  logic [AddrW-1:0] phys_q, phys_d;
  tok_t             last;

  assign in_acc     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  always_comb begin
    tok_in        = '0;
    tok_in.vld    = in_acc;
    tok_in.cmd    = cmd_e'(command_i);
    tok_in.done   = 1'b0;
    tok_in.status = StOk;
    tok_in.addr   = logical_addr_i;
    tok_in.len    = range_length_i;
    tok_in.tgt    = physical_base_i;
  end

  assign tok[0] = tok_in;

  assign last = tok[MaxEntries];
  assign adv  = !(last.vld && out_vld_q && out_stall_i);

  // Entries fill from cell 0 up, so insertion order is chain order and the
  // first covering cell the token meets is the earliest inserted one.
  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    ratt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // Result formed at the chain exit: an unfinished insert found no free cell,
  // an unfinished translate found no covering range.
  always_comb begin
    status_d = last.status;
    phys_d   = '0;
    if (!last.done) begin
      status_d = (last.cmd == CmdInsert) ? StFull : StNoMap;
    end else if (last.cmd == CmdTranslate) begin
      phys_d = last.tgt + last.len;   // wraps modulo 2^64
    end
  end

  assign out_load = last.vld && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc)        busy_q <= 1'b1;
      else if (out_load) busy_q <= 1'b0;
      if (out_load)          out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      phys_q   <= phys_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign physical_addr_o = phys_q;

endmodule

`default_nettype wire

>>> hdl/ratt_checker.sv
// Port-level checks of the range address translation table, bound to the top.
// Depends on ratt_pkg and range_address_translation_table_core_defines.svh.
`default_nettype none
`include "range_address_translation_table_core_defines.svh"

module ratt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [ratt_pkg::StatusW-1:0] status_o,
  input wire logic [ratt_pkg::AddrW-1:0]   physical_addr_o
);
  import ratt_pkg::*;

  `RATT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(physical_addr_o), "stalled result changed")

  `RATT_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "request accepted while another is in the chain")

  `RATT_ASSERT(a_zero_phys, clk_i, rst_ni, out_valid_o && (status_o != StOk) |-> physical_addr_o == '0, "non-ok result carries an address")

  `RATT_ASSERT(a_free_on_result, clk_i, rst_ni, $rose(out_valid_o) |-> !in_stall_o, "chain still busy when result appears")

endmodule

bind range_address_translation_table_core ratt_checker u_ratt_checker (.*);

`default_nettype wire

>>> tb/ratt_translation_checker.sv
// Response checker for range_address_translation_table_core: keeps a shadow
// copy of the range table and checks every response in order.
// Depends on ratt_pkg.

module ratt_translation_checker #(
  parameter int MaxEntries = ratt_pkg::MaxEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         command_i,
  input  logic [ratt_pkg::AddrW-1:0]   logical_addr_i,
  input  logic [ratt_pkg::AddrW-1:0]   range_length_i,
  input  logic [ratt_pkg::AddrW-1:0]   physical_base_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [ratt_pkg::StatusW-1:0] status_i,
  input  logic [ratt_pkg::AddrW-1:0]   physical_addr_i,
  output int                           error_count_o,
  output int                           pending_o
);
  import ratt_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] phys;
  } outcome_t;

  logic [AddrW-1:0] map_base [MaxEntries];
  logic [AddrW-1:0] map_len  [MaxEntries];
  logic [AddrW-1:0] map_phys [MaxEntries];
  int               map_used;
  outcome_t         awaited_q[$];

  // Applies one request to the shadow table and returns its response.
  function automatic outcome_t resolve_request(cmd_e cmd, logic [AddrW-1:0] addr,
                                               logic [AddrW-1:0] len,
                                               logic [AddrW-1:0] tgt);
    outcome_t         res;
    logic [AddrW-1:0] off;
    res.status = StNoMap;
    res.phys   = '0;
    if (cmd == CmdInsert) begin
      res.status = StOk;
      // duplicate test comes first, so a repeated base wins over a full table
      for (int i = 0; i < map_used; i++)
        if (map_base[i] == addr) res.status = StDup;
      if (res.status == StOk && map_used >= MaxEntries) res.status = StFull;
      if (res.status == StOk) begin
        map_base[map_used] = addr;
        map_len[map_used]  = len;
        map_phys[map_used] = tgt;
        map_used++;
      end
    end else begin
      // walk newest to oldest so the oldest covering range is the one kept
      for (int i = map_used - 1; i >= 0; i--) begin
        off = addr - map_base[i];
        if (addr >= map_base[i] && off < map_len[i]) begin
          res.status = StOk;
          res.phys   = map_phys[i] + off;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      map_used = 0;
      awaited_q.delete();
      error_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected response: status %0d physical_addr %h", status_i,
                 physical_addr_i);
          error_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            error_count_o++;
          end
          if (physical_addr_i !== want.phys) begin
            $error("physical_addr: expected %h, got %h", want.phys, physical_addr_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q.push_back(resolve_request(cmd_e'(command_i), logical_addr_i,
                                            range_length_i, physical_base_i));
      pending_o = awaited_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Top of the range translation table testbench: clock, reset, request and
// stall generation, and the final verdict.
// Depends on ratt_pkg, range_address_translation_table_core, ratt_translation_checker.

module tb;
  import ratt_pkg::*;

  localparam int MaxEntries  = MaxEntriesDefault;
  localparam int RandomItems = 1150;
  // hang guard for the slowest run: ~1200 requests, each a full chain walk plus
  // long sender gaps and output stalls
  localparam int CycleLimit  = 800000;
  // drain covers the MaxEntries cell registers of the chain plus the output register
  localparam int DrainCycles = MaxEntries + 16;

  localparam logic [AddrW-1:0] AllOnes     = {AddrW{1'b1}};
  localparam logic [AddrW-1:0] TopBit      = {1'b1, {(AddrW-1){1'b0}}};
  // bases packed into one small window so ranges overlap often
  localparam logic [AddrW-1:0] ClusterBase = 64'h0000_4000_0000_0000;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               command_i       = 1'b0;
  logic [AddrW-1:0]   logical_addr_i  = '0;
  logic [AddrW-1:0]   range_length_i  = '0;
  logic [AddrW-1:0]   physical_base_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [AddrW-1:0]   physical_addr_o;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;

  // ranges sent so far, used to aim lookups near them and to repeat bases on inserts
  logic [AddrW-1:0] sent_base[$];
  logic [AddrW-1:0] sent_len[$];

  range_address_translation_table_core #(
    .MaxEntries(MaxEntries)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .logical_addr_i (logical_addr_i),
    .range_length_i (range_length_i),
    .physical_base_i(physical_base_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .physical_addr_o(physical_addr_o)
  );

  ratt_translation_checker #(
    .MaxEntries(MaxEntries)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .logical_addr_i (logical_addr_i),
    .range_length_i (range_length_i),
    .physical_base_i(physical_base_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .physical_addr_i(physical_addr_o),
    .error_count_o  (mismatch_count),
    .pending_o      (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // hang guard
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: errors");
    $finish;
  end

  function automatic logic [AddrW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Presents one request at the falling edge and holds it until the block
  // takes it. Valid stays high on return, so back-to-back calls form a burst.
  task automatic send_req(input cmd_e cmd, input logic [AddrW-1:0] addr,
                          input logic [AddrW-1:0] len, input logic [AddrW-1:0] tgt);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    logical_addr_i  <= addr;
    range_length_i  <= len;
    physical_base_i <= tgt;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CmdInsert) begin
      sent_base.push_back(addr);
      sent_len.push_back(len);
    end
  endtask

  // Receiver: stretches of random length, each with its own stall density,
  // including stretches that never stall.
  initial begin
    int stretch;
    int pct;
    wait (rst_ni);
    forever begin
      stretch = $urandom_range(4, 120);
      case ($urandom_range(3))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (stretch) begin
        @(negedge clk_i);
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  initial begin
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] tgt;
    logic [AddrW-1:0] addr;
    int               burst_left;
    int               gap;
    int               k;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // lookups on an empty table
    send_req(CmdTranslate, '0, '0, '0);
    send_req(CmdTranslate, AllOnes, AllOnes, AllOnes);
    // zero-length range is stored but covers nothing
    send_req(CmdInsert, '0, '0, 64'h1234);
    send_req(CmdTranslate, '0, '0, '0);
    // same base again: ignored, old range kept
    send_req(CmdInsert, '0, 64'h5, 64'h9999);
    send_req(CmdTranslate, '0, '0, '0);
    // two overlapping ranges; the older one must win where both cover
    send_req(CmdInsert, 64'h1000, 64'h1000, 64'hA000);
    send_req(CmdInsert, 64'h0800, 64'h2000, 64'hB000);
    send_req(CmdTranslate, 64'h1800, '0, '0);
    send_req(CmdTranslate, 64'h0900, '0, '0);
    send_req(CmdTranslate, 64'h2000, '0, '0);
    // one past the end of the second range
    send_req(CmdTranslate, 64'h2800, '0, '0);
    // range at the top of the address space with maximum length: must not
    // wrap around to low addresses; physical sum wraps though
    send_req(CmdInsert, AllOnes - 64'hF, AllOnes, AllOnes);
    send_req(CmdTranslate, AllOnes, '0, '0);
    send_req(CmdTranslate, AllOnes - 64'hF, '0, '0);
    send_req(CmdTranslate, 64'h5, '0, '0);
    // single-byte range at the top bit
    send_req(CmdInsert, TopBit, 64'h1, '0);
    send_req(CmdTranslate, TopBit, '0, '0);
    send_req(CmdTranslate, TopBit + 64'h1, '0, '0);
    send_req(CmdTranslate, TopBit - 64'h1, '0, '0);
    // repeated base with a new length must not change the stored range
    send_req(CmdInsert, 64'h1000, 64'h8000, 64'hC000);
    send_req(CmdTranslate, 64'h1FFF, AllOnes, AllOnes);
    send_req(CmdTranslate, 64'h2FFF, AllOnes, AllOnes);

    // ---- random part ----
    // roughly one request in six is an insert, so the table fills around
    // the middle of the run and the rest exercises full and duplicate cases
    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // mostly short gaps; some long enough to land anywhere in a chain walk
        gap = ($urandom_range(4) == 0) ? $urandom_range(1, 80) : $urandom_range(0, 3);
        if (gap != 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      burst_left--;

      if ($urandom_range(5) == 0) begin
        case ($urandom_range(7))
          0:       len = '0;
          1:       len = AllOnes;
          2:       len = rand_word();
          3:       len = {32'h0, $urandom};
          default: len = AddrW'($urandom_range(1, 4096));
        endcase
        if (sent_base.size() != 0 && $urandom_range(4) == 0) begin
          base = sent_base[$urandom_range(sent_base.size() - 1)];
        end else begin
          case ($urandom_range(3))
            0:       base = rand_word();
            1:       base = AllOnes - AddrW'($urandom_range(0, 4095));
            default: base = ClusterBase + AddrW'($urandom_range(0, 65535));
          endcase
        end
        case ($urandom_range(7))
          0:       tgt = '0;
          1:       tgt = AllOnes;
          default: tgt = rand_word();
        endcase
        send_req(CmdInsert, base, len, tgt);
      end else begin
        if (sent_base.size() != 0 && $urandom_range(9) < 7) begin
          // aim at a sent range: inside, on its edges, or just outside
          k = $urandom_range(sent_base.size() - 1);
          case ($urandom_range(5))
            0:       addr = sent_base[k];
            1:       addr = sent_base[k] - 64'h1;
            2:       addr = sent_base[k] + sent_len[k];
            3:       addr = sent_base[k] + sent_len[k] - 64'h1;
            default: addr = (sent_len[k] == 0) ? sent_base[k]
                                               : sent_base[k] + rand_word() % sent_len[k];
          endcase
        end else if ($urandom_range(1) == 0) begin
          addr = ClusterBase + AddrW'($urandom_range(0, 70000));
        end else begin
          addr = rand_word();
        end
        // length and physical base are unused on a lookup; keep them noisy
        send_req(CmdTranslate, addr, rand_word(), rand_word());
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // wait for every response, then let the chain run dry
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ratt_pkg.sv
hdl/ratt_cell.sv
hdl/range_address_translation_table_core.sv
hdl/ratt_checker.sv
tb/ratt_translation_checker.sv
tb/tb.sv
